// ===== design/glce_pkg.sv =====
package glce_pkg;
	localparam int MAX_NODES = 64;
	localparam int MAX_CHAIN_ELEMS = 256;
	localparam int MAX_CHAINS = 64;
	localparam int KEY_BITS = 32;
	localparam int NID_W = $clog2(MAX_NODES);
	localparam int NCNT_W = $clog2(MAX_NODES + 1);
	localparam int EID_W = $clog2(MAX_CHAIN_ELEMS);
	localparam int ECNT_W = $clog2(MAX_CHAIN_ELEMS + 1);
	localparam int CID_W = $clog2(MAX_CHAINS);
	localparam int CCNT_W = $clog2(MAX_CHAINS + 1);

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_COMPUTE = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_SELF = 3'd1;
	localparam logic [2:0] ST_NODE_FULL = 3'd2;
	localparam logic [2:0] ST_STORE_FULL = 3'd3;
	localparam logic [2:0] ST_RANGE = 3'd4;

	typedef logic [MAX_NODES-1:0] row_t;

	// lowest set bit, one-hot
	function automatic row_t lowest_bit(row_t r);
		return r & (~r + row_t'(1));
	endfunction

	function automatic logic [NID_W-1:0] onehot_idx(row_t r);
		logic [NID_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < MAX_NODES; i++)
			if (r[i]) idx = idx | NID_W'(i);
		return idx;
	endfunction
endpackage

// ===== design/graph_link_chain_extractor_core.sv =====
// Work per item: add compares the stored keys one by one, then writes both adjacency rows;
//   it skips the writes when the node table is full. Self link, kind 3, idle compute and an
//   out-of-range chain index finish without further work; query ends early when the position is
//   out of range. Compute grows with row visits, elements pushed, links followed, swapped pairs and chains.
// Throughput: one item at a time; busy from start until the done cycle, which can take the next.
// Reset clears state, counters and the adjacency valid bits; results cannot be stalled.
module graph_link_chain_extractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  kind,
	input  logic [31:0] key_a,
	input  logic [31:0] key_b,
	input  logic [5:0]  chain_index,
	input  logic [7:0]  element_position,
	output logic [2:0]  status,
	output logic [6:0]  chain_count,
	output logic [8:0]  chain_length,
	output logic [31:0] element_key,
	output logic        element_valid
);
	localparam int NW = glce_pkg::NID_W;
	localparam int NC = glce_pkg::NCNT_W;
	localparam int EW = glce_pkg::EID_W;
	localparam int EC = glce_pkg::ECNT_W;
	localparam int CW = glce_pkg::CID_W;
	localparam int CC = glce_pkg::CCNT_W;
	localparam int KB = glce_pkg::KEY_BITS;

	localparam logic [4:0] S_IDLE = 5'd0, S_FA = 5'd1, S_FA_W = 5'd2, S_FB = 5'd3,
		S_ADD1 = 5'd4, S_ADD1_W = 5'd5, S_ADD2 = 5'd6, S_ADD2_W = 5'd7,
		S_SCAN = 5'd8, S_SCAN_W = 5'd9, S_RM_B = 5'd10, S_RM_B_W = 5'd11,
		S_WALK = 5'd12, S_WALK_W = 5'd13, S_WALK_X = 5'd14, S_WALK_XW = 5'd15,
		S_REV_R = 5'd16, S_REV_R2 = 5'd17, S_REV_W1 = 5'd18, S_REV_W2 = 5'd19,
		S_COMMIT = 5'd20, S_CLEAR = 5'd21, S_Q1 = 5'd22, S_Q2 = 5'd23, S_Q3 = 5'd24,
		S_Q4 = 5'd25, S_Q5 = 5'd26, S_DONE = 5'd27;

	logic [4:0] st_q;
	logic [KB-1:0] ka_q, kb_q;
	logic [NC-1:0] node_count_q, idx_q;
	logic [NW-1:0] ia_q, ib_q, cur_q, a_q, b_q, nx_q, tmp_q;
	logic ia_hit_q, ib_hit_q, pass2_q;
	logic [CC-1:0] chains_q;
	logic [EC-1:0] used_q, len_q, lo_q, hi_q;
	logic pending_q;
	logic [2:0] status_q;
	logic [8:0] length_q;
	logic [31:0] ekey_q;
	logic evalid_q;
	logic [CW-1:0] ci_q;
	logic [7:0] pos_q;
	logic [EC-1:0] start_q;

	// memories
	logic [KB-1:0] keys_mem [glce_pkg::MAX_NODES];
	logic [KB-1:0] key_rd;
	logic          key_we;
	logic [NW-1:0] key_wa, key_ra;
	logic [KB-1:0] key_wd;
	always_ff @(posedge clk) begin
		if (key_we) keys_mem[key_wa] <= key_wd;
		key_rd <= keys_mem[key_ra];
	end

	glce_pkg::row_t adj_mem [glce_pkg::MAX_NODES];
	logic [glce_pkg::MAX_NODES-1:0] adj_vld_q;
	glce_pkg::row_t adj_rd_raw, adj_rd, adj_wd;
	logic adj_we, adj_rv_q;
	logic [NW-1:0] adj_a;
	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_a] <= adj_wd;
		adj_rd_raw <= adj_mem[adj_a];
	end
	assign adj_rd = adj_rv_q ? adj_rd_raw : '0;

	logic [NW-1:0] el_mem [glce_pkg::MAX_CHAIN_ELEMS];
	logic [NW-1:0] el_rd, el_wd;
	logic el_we;
	logic [EW-1:0] el_wa, el_ra;
	always_ff @(posedge clk) begin
		if (el_we) el_mem[el_wa] <= el_wd;
		el_rd <= el_mem[el_ra];
	end

	logic [EC-1:0] end_mem [glce_pkg::MAX_CHAINS];
	logic [EC-1:0] end_rd;
	logic end_we;
	logic [CW-1:0] end_wa, end_ra;
	logic [EC-1:0] end_wd;
	always_ff @(posedge clk) begin
		if (end_we) end_mem[end_wa] <= end_wd;
		end_rd <= end_mem[end_ra];
	end

	logic [NW-1:0] elow;
	logic deg1, rowz;
	logic [EC-1:0] pos_abs;
	logic [NC-1:0] need;
	assign elow = glce_pkg::onehot_idx(glce_pkg::lowest_bit(adj_rd));
	assign deg1 = (adj_rd != '0) && ((adj_rd & (adj_rd - glce_pkg::row_t'(1))) == '0);
	assign rowz = (adj_rd == '0);
	assign pos_abs = used_q + len_q;
	assign need = NC'(!ia_hit_q) + NC'(!ib_hit_q);

	always_comb begin
		key_we = 1'b0; key_wa = ia_q; key_wd = ka_q; key_ra = idx_q[NW-1:0];
		adj_we = 1'b0; adj_a = cur_q; adj_wd = adj_rd;
		el_we = 1'b0; el_wa = pos_abs[EW-1:0]; el_wd = cur_q; el_ra = lo_q[EW-1:0];
		end_we = 1'b0; end_wa = chains_q[CW-1:0]; end_wd = pos_abs; end_ra = ci_q;
		case (st_q)
			S_ADD1: begin
				key_we = !ia_hit_q; key_wa = ia_q; key_wd = ka_q;
				adj_a = ia_q;
			end
			S_ADD1_W: begin
				key_we = !ib_hit_q; key_wa = ib_q; key_wd = kb_q;
				adj_a = ia_q; adj_we = 1'b1;
				adj_wd = adj_rd | (glce_pkg::row_t'(1) << ib_q);
			end
			S_ADD2: adj_a = ib_q;
			S_ADD2_W: begin
				adj_a = ib_q; adj_we = 1'b1;
				adj_wd = adj_rd | (glce_pkg::row_t'(1) << ia_q);
			end
			S_SCAN: adj_a = idx_q[NW-1:0];
			S_SCAN_W: begin
				// first link of the row starts a chain: drop it from this row
				adj_a = idx_q[NW-1:0];
				adj_we = !rowz && (chains_q < CC'(glce_pkg::MAX_CHAINS));
				adj_wd = adj_rd & ~glce_pkg::lowest_bit(adj_rd);
			end
			S_RM_B: adj_a = b_q;
			S_RM_B_W: begin
				adj_a = b_q; adj_we = 1'b1;
				adj_wd = adj_rd & ~(glce_pkg::row_t'(1) << a_q);
			end
			S_WALK: el_we = (pos_abs < EC'(glce_pkg::MAX_CHAIN_ELEMS));
			S_WALK_W: begin
				// degree one: the only link goes, row becomes empty
				adj_we = deg1; adj_wd = '0;
			end
			S_WALK_X: adj_a = nx_q;
			S_WALK_XW: begin
				adj_a = nx_q; adj_we = 1'b1;
				adj_wd = adj_rd & ~(glce_pkg::row_t'(1) << cur_q);
			end
			S_REV_R2: el_ra = hi_q[EW-1:0];
			S_REV_W1: begin
				el_we = 1'b1; el_wa = lo_q[EW-1:0]; el_wd = el_rd;
			end
			S_REV_W2: begin
				el_we = 1'b1; el_wa = hi_q[EW-1:0]; el_wd = tmp_q;
			end
			S_COMMIT: end_we = 1'b1;
			S_Q1: end_ra = ci_q - CW'(1);
			S_Q3: el_ra = EW'(start_q + EC'(pos_q));
			S_Q4: key_ra = el_rd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; node_count_q <= '0; chains_q <= '0; used_q <= '0;
			pending_q <= 1'b0; adj_vld_q <= '0; adj_rv_q <= 1'b0; done <= 1'b0;
			ka_q <= '0; kb_q <= '0; idx_q <= '0; ia_q <= '0; ib_q <= '0;
			cur_q <= '0; a_q <= '0; b_q <= '0; nx_q <= '0; tmp_q <= '0;
			ia_hit_q <= 1'b0; ib_hit_q <= 1'b0; pass2_q <= 1'b0;
			len_q <= '0; lo_q <= '0; hi_q <= '0; start_q <= '0;
			status_q <= glce_pkg::ST_OK; length_q <= '0; ekey_q <= '0; evalid_q <= 1'b0;
			ci_q <= '0; pos_q <= '0;
		end else begin
			done <= (st_q == S_DONE);
			adj_rv_q <= adj_vld_q[adj_a];
			if (st_q == S_CLEAR) adj_vld_q <= '0;
			else if (adj_we) adj_vld_q[adj_a] <= 1'b1;
			case (st_q)
				S_IDLE: if (start) begin
					ka_q <= KB'(key_a); kb_q <= KB'(key_b);
					ci_q <= chain_index; pos_q <= element_position;
					idx_q <= '0; ia_hit_q <= 1'b0; ib_hit_q <= 1'b0;
					length_q <= '0; ekey_q <= '0; evalid_q <= 1'b0;
					case (kind)
						glce_pkg::KIND_ADD: begin
							if (KB'(key_a) == KB'(key_b)) begin
								status_q <= glce_pkg::ST_SELF; st_q <= S_DONE;
							end else begin
								status_q <= glce_pkg::ST_OK; st_q <= S_FA;
							end
						end
						glce_pkg::KIND_COMPUTE: begin
							status_q <= glce_pkg::ST_OK;
							if (pending_q) begin
								pending_q <= 1'b0; st_q <= S_SCAN;
							end else st_q <= S_DONE;
						end
						glce_pkg::KIND_QUERY: begin
							if (CC'(chain_index) >= chains_q) begin
								status_q <= glce_pkg::ST_RANGE; st_q <= S_DONE;
							end else begin
								status_q <= glce_pkg::ST_OK; st_q <= S_Q1;
							end
						end
						default: begin
							status_q <= glce_pkg::ST_OK; st_q <= S_DONE;
						end
					endcase
				end
				S_FA: st_q <= (idx_q < node_count_q) ? S_FA_W : S_FB;
				S_FA_W: begin
					if (key_rd == ka_q && !ia_hit_q) begin
						ia_hit_q <= 1'b1; ia_q <= idx_q[NW-1:0];
					end
					if (key_rd == kb_q && !ib_hit_q) begin
						ib_hit_q <= 1'b1; ib_q <= idx_q[NW-1:0];
					end
					idx_q <= idx_q + NC'(1);
					st_q <= S_FA;
				end
				S_FB: begin
					if (node_count_q + need > NC'(glce_pkg::MAX_NODES)) begin
						status_q <= glce_pkg::ST_NODE_FULL; st_q <= S_DONE;
					end else begin
						if (!ia_hit_q) ia_q <= node_count_q[NW-1:0];
						if (!ib_hit_q)
							ib_q <= NW'(node_count_q + NC'(!ia_hit_q));
						node_count_q <= node_count_q + need;
						pending_q <= 1'b1;
						st_q <= S_ADD1;
					end
				end
				S_ADD1: st_q <= S_ADD1_W;
				S_ADD1_W: st_q <= S_ADD2;
				S_ADD2: st_q <= S_ADD2_W;
				S_ADD2_W: st_q <= S_DONE;
				// rows below the scan index are already empty; each compute starts the scan at row zero
				S_SCAN: st_q <= (idx_q < node_count_q) ? S_SCAN_W : S_DONE;
				S_SCAN_W: begin
					if (rowz) begin
						idx_q <= idx_q + NC'(1); st_q <= S_SCAN;
					end else if (chains_q >= CC'(glce_pkg::MAX_CHAINS)) begin
						status_q <= glce_pkg::ST_STORE_FULL; st_q <= S_CLEAR;
					end else begin
						a_q <= idx_q[NW-1:0]; b_q <= elow; len_q <= '0; pass2_q <= 1'b0;
						st_q <= S_RM_B;
					end
				end
				S_RM_B: st_q <= S_RM_B_W;
				S_RM_B_W: begin
					cur_q <= a_q; st_q <= S_WALK;
				end
				S_WALK: begin
					if (pos_abs >= EC'(glce_pkg::MAX_CHAIN_ELEMS)) begin
						status_q <= glce_pkg::ST_STORE_FULL; st_q <= S_CLEAR;
					end else begin
						len_q <= len_q + EC'(1); st_q <= S_WALK_W;
					end
				end
				S_WALK_W: begin
					if (deg1) begin
						nx_q <= elow; st_q <= S_WALK_X;
					end else if (!pass2_q) begin
						pass2_q <= 1'b1;
						lo_q <= used_q; hi_q <= pos_abs - EC'(1);
						st_q <= S_REV_R;
					end else st_q <= S_COMMIT;
				end
				S_WALK_X: st_q <= S_WALK_XW;
				S_WALK_XW: begin
					cur_q <= nx_q; st_q <= S_WALK;
				end
				S_REV_R: begin
					if (lo_q < hi_q) st_q <= S_REV_R2;
					else begin
						cur_q <= b_q; st_q <= S_WALK;
					end
				end
				S_REV_R2: begin
					tmp_q <= el_rd; st_q <= S_REV_W1;
				end
				S_REV_W1: st_q <= S_REV_W2;
				S_REV_W2: begin
					lo_q <= lo_q + EC'(1); hi_q <= hi_q - EC'(1); st_q <= S_REV_R;
				end
				S_COMMIT: begin
					used_q <= pos_abs; chains_q <= chains_q + CC'(1); st_q <= S_SCAN;
				end
				S_CLEAR: st_q <= S_DONE;
				S_Q1: st_q <= S_Q2;
				S_Q2: begin
					start_q <= (ci_q == '0) ? '0 : end_rd; st_q <= S_Q3;
				end
				S_Q3: begin
					length_q <= 9'(end_rd - start_q);
					if (EC'(pos_q) >= end_rd - start_q) begin
						status_q <= glce_pkg::ST_RANGE; st_q <= S_DONE;
					end else st_q <= S_Q4;
				end
				S_Q4: st_q <= S_Q5;
				S_Q5: begin
					ekey_q <= 32'(key_rd); evalid_q <= 1'b1; st_q <= S_DONE;
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
	assign status = status_q;
	assign chain_count = 7'(chains_q);
	assign chain_length = length_q;
	assign element_key = ekey_q;
	assign element_valid = evalid_q;

	logic done_d;
	always_ff @(posedge clk or negedge arst_n)
		if (!arst_n) done_d <= 1'b0; else done_d <= done;

	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		node_count_q <= NC'(glce_pkg::MAX_NODES)) else $error("node count overflow");
	a_chain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chains_q <= CC'(glce_pkg::MAX_CHAINS)) else $error("chain count overflow");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_d |-> !done) else $error("double done");
endmodule
